/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the byte deque.
// Needs nothing else; a file takes it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define BDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("byte deque check failed");

// Next-cycle implication, reset-qualified.
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("byte deque check failed");

`endif

/* rtl/bdq_pkg.sv */
// Package of the byte deque: sizes, opcodes, item types, command/status types.
// Depends on nothing; every other file of the block but assert_macros.svh uses it.
`default_nettype none

package bdq_pkg;

   localparam int DEPTH  = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int OP_W   = 3;
   localparam int DATA_W = 8;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = OP_W'(0);
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = OP_W'(1);
   localparam logic [OP_W-1:0] OP_POP_FRONT  = OP_W'(2);
   localparam logic [OP_W-1:0] OP_POP_BACK   = OP_W'(3);
   localparam logic [OP_W-1:0] OP_DUMP       = OP_W'(4);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              empty_res;
      logic              overflow;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
      logic dump_start;
      logic dump_next;
      logic load_flag;
      logic flag_empty;
      logic flag_ovf;
      logic load_mem;
      logic mem_last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic dump_last;
      logic out_last;
   } sts_type;

   function automatic addr_type ring_add(addr_type base, cnt_type offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/bdq_ctrl.sv */
// Controller of the byte deque: decodes opcodes and sequences pops and dumps.
// Depends on bdq_pkg; drives the datapath bdq_dpath by command struct.
`default_nettype none

module bdq_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [bdq_pkg::OP_W-1:0]    req_opcode,
   output logic                             req_stall,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire bdq_pkg::sts_type            sts,
   output bdq_pkg::cmd_type                 cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       dumping_ff, dumping_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in   = state_ff;
      dumping_in = dumping_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode) inside
                  bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                     if (sts.full) begin
                        cmd.load_flag = 1'b1;
                        cmd.flag_ovf  = 1'b1;
                        state_in      = S_OUT;
                     end else begin
                        cmd.push_front = (req_opcode == bdq_pkg::OP_PUSH_FRONT);
                        cmd.push_back  = (req_opcode == bdq_pkg::OP_PUSH_BACK);
                     end
                  end
                  bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                     dumping_in = 1'b0;
                     if (sts.empty) begin
                        cmd.load_flag  = 1'b1;
                        cmd.flag_empty = 1'b1;
                        state_in       = S_OUT;
                     end else begin
                        cmd.pop_front = (req_opcode == bdq_pkg::OP_POP_FRONT);
                        cmd.pop_back  = (req_opcode == bdq_pkg::OP_POP_BACK);
                        state_in      = S_READ;
                     end
                  end
                  bdq_pkg::OP_DUMP: begin
                     if (sts.empty) begin
                        dumping_in     = 1'b0;
                        cmd.load_flag  = 1'b1;
                        cmd.flag_empty = 1'b1;
                        state_in       = S_OUT;
                     end else begin
                        dumping_in     = 1'b1;
                        cmd.dump_start = 1'b1;
                        state_in       = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.load_mem = 1'b1;
            cmd.mem_last = !dumping_ff || sts.dump_last;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (dumping_ff && !sts.out_last) begin
                  cmd.dump_next = 1'b1;
                  state_in      = S_READ;
               end else begin
                  dumping_in = 1'b0;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         dumping_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dumping_ff <= dumping_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/bdq_dpath.sv */
// Datapath of the byte deque: ring store, front pointer, occupancy, dump index
// and result register. Depends on bdq_pkg; driven by bdq_ctrl.
`default_nettype none

module bdq_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bdq_pkg::cmd_type              cmd,
   input  wire logic [bdq_pkg::DATA_W-1:0]    wr_value,
   output bdq_pkg::sts_type                   sts,
   output bdq_pkg::rsp_type                   rsp
);

   logic [bdq_pkg::DATA_W-1:0] store_ff [bdq_pkg::DEPTH];
   logic [bdq_pkg::DATA_W-1:0] rd_data_ff;

   bdq_pkg::addr_type front_ff, front_in;
   bdq_pkg::cnt_type  occ_ff, occ_in;
   bdq_pkg::addr_type idx_ff, idx_in;
   bdq_pkg::rsp_type  rsp_ff, rsp_in;

   bdq_pkg::addr_type front_dec, front_inc, wr_addr, rd_addr;
   bdq_pkg::cnt_type  rd_offset;
   logic              wr_en, rd_en;

   assign front_dec = (front_ff == '0) ? bdq_pkg::addr_type'(bdq_pkg::DEPTH - 1)
                                       : front_ff - 1'b1;
   assign front_inc = (front_ff == bdq_pkg::addr_type'(bdq_pkg::DEPTH - 1)) ? '0
                                       : front_ff + 1'b1;

   assign wr_en   = cmd.push_front | cmd.push_back;
   assign rd_en   = cmd.pop_front | cmd.pop_back | cmd.dump_start | cmd.dump_next;
   assign wr_addr = cmd.push_front ? front_dec : bdq_pkg::ring_add(front_ff, occ_ff);

   always_comb begin
      if (cmd.pop_back) begin
         rd_offset = occ_ff - 1'b1;
      end else if (cmd.dump_next) begin
         rd_offset = bdq_pkg::cnt_type'(idx_ff) + 1'b1;
      end else begin
         rd_offset = '0;
      end
   end

   assign rd_addr = bdq_pkg::ring_add(front_ff, rd_offset);

   always_comb begin
      front_in = front_ff;
      occ_in   = occ_ff;
      idx_in   = idx_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
      end else if (cmd.pop_front) begin
         front_in = front_inc;
      end
      if (wr_en) begin
         occ_in = occ_ff + 1'b1;
      end else if (cmd.pop_front || cmd.pop_back) begin
         occ_in = occ_ff - 1'b1;
      end
      if (cmd.dump_start) begin
         idx_in = '0;
      end else if (cmd.dump_next) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_flag) begin
         rsp_in.data      = '0;
         rsp_in.empty_res = cmd.flag_empty;
         rsp_in.overflow  = cmd.flag_ovf;
         rsp_in.last      = 1'b1;
      end else if (cmd.load_mem) begin
         rsp_in.data      = rd_data_ff;
         rsp_in.empty_res = 1'b0;
         rsp_in.overflow  = 1'b0;
         rsp_in.last      = cmd.mem_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_value;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         occ_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         front_ff <= front_in;
         occ_ff   <= occ_in;
         idx_ff   <= idx_in;
      end
      rsp_ff <= rsp_in;
   end

   assign sts.full      = (occ_ff == bdq_pkg::cnt_type'(bdq_pkg::DEPTH));
   assign sts.empty     = (occ_ff == '0);
   assign sts.dump_last = ((bdq_pkg::cnt_type'(idx_ff) + 1'b1) == occ_ff);
   assign sts.out_last  = rsp_ff.last;
   assign rsp           = rsp_ff;

endmodule

`default_nettype wire

/* rtl/byte_deque.sv */
// Push front/back: one item per cycle while idle, no result; a push into a full
// store gives its overflow item in the cycle after acceptance. Pop: the result
// item passes the store read register, then the result register, and the next
// item is taken the cycle after the result is taken. Dump of N entries: one
// entry at a time through the single store read port. Synchronous reset empties
// the deque and idles the controller; store contents are not cleared.
`default_nettype none

module byte_deque (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bdq_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bdq_pkg::rsp_type      rsp_item
);

   bdq_pkg::cmd_type cmd;
   bdq_pkg::sts_type sts;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_item.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   bdq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_value (req_item.value),
      .sts      (sts),
      .rsp      (rsp_item)
   );

endmodule

`default_nettype wire

/* rtl/bdq_checker.sv */
// Port-level checker of the byte deque, bound to the top level.
// Depends on bdq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bdq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire bdq_pkg::req_type req_item,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire bdq_pkg::rsp_type rsp_item
);

   logic req_seen;

   assign req_seen = req_valid && (req_item.opcode != bdq_pkg::OP_PUSH_FRONT ||
                                   req_item.opcode == bdq_pkg::OP_PUSH_FRONT);

   `BDQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))
   `BDQ_ASSERT_NOW(a_no_accept_pending, clock, reset, rsp_valid, req_stall || !req_seen)
   `BDQ_ASSERT_NOW(a_one_flag, clock, reset, rsp_valid, !(rsp_item.empty_res && rsp_item.overflow))
   `BDQ_ASSERT_NOW(a_flag_form, clock, reset, rsp_valid && (rsp_item.empty_res || rsp_item.overflow), rsp_item.last && rsp_item.data == '0)
   `BDQ_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && !rsp_stall && rsp_item.last, !rsp_valid)

endmodule

bind byte_deque bdq_checker u_chk (.*);

`default_nettype wire

/* tb/tb_byte_deque.sv */
// Self-checking testbench for byte_deque: directed table, then random items
// under several idle/stall mixes, all checked against an internal deque model.
// Depends on bdq_pkg and the byte_deque RTL.

module tb_byte_deque;
   import bdq_pkg::*;

   typedef struct packed {
      logic    on;
      rsp_type rsp;
   } pin_type;

   typedef struct {
      logic [OP_W-1:0]   opcode;
      logic [DATA_W-1:0] value;
      int                reps;
      pin_type           pin;
   } row_type;

   localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_W'(5);
   localparam logic [OP_W-1:0] OP_UNUSED_HI = OP_W'(7);
   localparam rsp_type EMPTY_RSP = '{data: 8'h00, empty_res: 1'b1, overflow: 1'b0, last: 1'b1};
   localparam rsp_type OVF_RSP   = '{data: 8'h00, empty_res: 1'b0, overflow: 1'b1, last: 1'b1};
   localparam pin_type NO_PIN    = '0;
   localparam int QUIET_LIMIT     = 2000;
   localparam int TAIL_CYCLES     = 16;
   localparam int ITEMS_PER_PHASE = 5;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatch_cnt  = 0;
   int quiet_cycles  = 0;

   logic [DATA_W-1:0] shadow_ring [DEPTH];
   addr_type          shadow_front = '0;
   cnt_type           shadow_fill  = '0;
   rsp_type           deque_out_q [$];
   pin_type           pin_q [$];
   row_type           rows [$];

   byte_deque u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic deque_apply(input req_type it);
      rsp_type r;
      addr_type slot;
      r = '0;
      r.last = 1'b1;
      case (it.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (int'(shadow_fill) >= DEPTH) begin
               r.overflow = 1'b1;
               deque_out_q.push_back(r);
            end else if (it.opcode == OP_PUSH_FRONT) begin
               shadow_front = addr_type'((int'(shadow_front) + DEPTH - 1) % DEPTH);
               shadow_ring[shadow_front] = it.value;
               shadow_fill = shadow_fill + 1'b1;
            end else begin
               slot = addr_type'((int'(shadow_front) + int'(shadow_fill)) % DEPTH);
               shadow_ring[slot] = it.value;
               shadow_fill = shadow_fill + 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_fill == 0) begin
               r.empty_res = 1'b1;
            end else if (it.opcode == OP_POP_FRONT) begin
               r.data = shadow_ring[shadow_front];
               shadow_front = addr_type'((int'(shadow_front) + 1) % DEPTH);
               shadow_fill = shadow_fill - 1'b1;
            end else begin
               slot = addr_type'((int'(shadow_front) + int'(shadow_fill) - 1) % DEPTH);
               r.data = shadow_ring[slot];
               shadow_fill = shadow_fill - 1'b1;
            end
            deque_out_q.push_back(r);
         end
         OP_DUMP: begin
            if (shadow_fill == 0) begin
               r.empty_res = 1'b1;
               deque_out_q.push_back(r);
            end else begin
               for (int i = 0; i < int'(shadow_fill); i++) begin
                  slot = addr_type'((int'(shadow_front) + i) % DEPTH);
                  r.data = shadow_ring[slot];
                  r.last = (i + 1 == int'(shadow_fill));
                  deque_out_q.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      pin_type pin;
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pin = pin_q.pop_front();
            deque_apply(req_item);
            if (pin.on) begin
               deque_out_q[deque_out_q.size() - 1] = pin.rsp;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (deque_out_q.size() == 0) begin
               $error("unexpected item: data %0h empty_res %0b overflow %0b last %0b",
                      rsp_item.data, rsp_item.empty_res, rsp_item.overflow, rsp_item.last);
               mismatch_cnt++;
            end else begin
               want = deque_out_q.pop_front();
               if (rsp_item.data !== want.data) begin
                  $error("data: expected %0h, got %0h", want.data, rsp_item.data);
                  mismatch_cnt++;
               end
               if (rsp_item.empty_res !== want.empty_res) begin
                  $error("empty_res: expected %0b, got %0b", want.empty_res, rsp_item.empty_res);
                  mismatch_cnt++;
               end
               if (rsp_item.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_item.overflow);
                  mismatch_cnt++;
               end
               if (rsp_item.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_item.last);
                  mismatch_cnt++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[byte_deque] ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(input req_type it, input pin_type pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pin_q.push_back(pin);
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (deque_out_q.size() != 0) @(posedge clock);
   endtask

   function automatic void add_row(logic [OP_W-1:0] op, logic [DATA_W-1:0] val, int reps,
                                   pin_type pin);
      row_type row;
      row.opcode = op;
      row.value  = val;
      row.reps   = reps;
      row.pin    = pin;
      rows.push_back(row);
   endfunction

   function automatic req_type pick_item(int mode);
      req_type it;
      int push_pct;
      int roll;
      case (mode)
         0:       push_pct = 80;
         1:       push_pct = 20;
         default: push_pct = 50;
      endcase
      it.value = DATA_W'($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 4) begin
         it.opcode = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end else if (roll < 12) begin
         it.opcode = OP_DUMP;
      end else if ($urandom_range(99) < push_pct) begin
         it.opcode = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
         it.opcode = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      return it;
   endfunction

   initial begin
      req_type it;
      int sent;
      int mode;

      add_row(OP_POP_FRONT,  8'h00, 1, '{1'b1, EMPTY_RSP});
      add_row(OP_POP_BACK,   8'hFF, 1, '{1'b1, EMPTY_RSP});
      add_row(OP_DUMP,       8'h00, 1, '{1'b1, EMPTY_RSP});
      add_row(OP_UNUSED_LO,  8'hFF, 1, NO_PIN);
      add_row(OP_UNUSED_HI,  8'h00, 1, NO_PIN);
      add_row(OP_PUSH_FRONT, 8'h00, 1, NO_PIN);
      add_row(OP_PUSH_BACK,  8'hFF, 1, NO_PIN);
      add_row(OP_PUSH_FRONT, 8'hA5, 1, NO_PIN);
      add_row(OP_PUSH_BACK,  8'h5A, 1, NO_PIN);
      add_row(OP_DUMP,       8'h00, 1, NO_PIN);
      add_row(OP_POP_FRONT,  8'h00, 1, NO_PIN);
      add_row(OP_POP_BACK,   8'h00, 1, NO_PIN);
      add_row(OP_POP_BACK,   8'h00, 1, NO_PIN);
      add_row(OP_POP_FRONT,  8'h00, 1, NO_PIN);
      add_row(OP_POP_FRONT,  8'h00, 1, '{1'b1, EMPTY_RSP});
      add_row(OP_PUSH_FRONT, 8'h80, DEPTH, NO_PIN);
      add_row(OP_PUSH_BACK,  8'h11, 1, '{1'b1, OVF_RSP});
      add_row(OP_PUSH_FRONT, 8'h22, 1, '{1'b1, OVF_RSP});
      add_row(OP_DUMP,       8'h00, 1, NO_PIN);
      add_row(OP_POP_FRONT,  8'h00, 5, NO_PIN);
      add_row(OP_PUSH_BACK,  8'hC0, 5, NO_PIN);
      add_row(OP_POP_BACK,   8'h00, DEPTH, NO_PIN);
      add_row(OP_DUMP,       8'h00, 1, '{1'b1, EMPTY_RSP});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[r]) begin
         for (int k = 0; k < rows[r].reps; k++) begin
            it.opcode = rows[r].opcode;
            it.value  = rows[r].value + DATA_W'(k);
            send_item(it, rows[r].pin);
         end
      end
      hold_until_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 85; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         sent = 0;
         mode = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (sent % 10 == 9) mode = $urandom_range(2);
            it = pick_item(mode);
            send_item(it, NO_PIN);
            if (it.opcode <= OP_DUMP) sent++;
         end
         hold_until_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("[byte_deque] OK");
      end else begin
         $display("[byte_deque] ERROR");
      end
      $finish;
   end

endmodule
